// ----- hdl/kscu_pkg.sv -----
// Package for the keyword substitution cipher unit.
// Holds the alphabet size, derived widths, action and status codes and the
// table push record. Depends on nothing.
`default_nettype none

package kscu_pkg;

    localparam int ALPHABET_SIZE = 26;  // letters starting at 'A', 2 to 32
    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int LEN_W = $clog2(ALPHABET_SIZE + 1);

    localparam logic [LEN_W-1:0] N_LEN = LEN_W'(ALPHABET_SIZE);

    // letter range checked on a 9-bit copy of the byte so 'A' + 32 still fits
    localparam logic [8:0] LETTER_BASE = 9'd65;
    localparam logic [8:0] LETTER_END  = 9'(65 + ALPHABET_SIZE);

    localparam logic [2:0] ACT_OPEN   = 3'd0;
    localparam logic [2:0] ACT_KEY    = 3'd1;
    localparam logic [2:0] ACT_CLOSE  = 3'd2;
    localparam logic [2:0] ACT_ENCODE = 3'd3;
    localparam logic [2:0] ACT_DECODE = 3'd4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_REPEAT     = 2'd1,
        ST_NOT_LETTER = 2'd2
    } t_status;

    // one value entering the tail of the forward row, and its position
    typedef struct packed {
        logic             shift;
        logic [IDX_W-1:0] val;
        logic [IDX_W-1:0] pos;
    } t_push;

endpackage

`default_nettype wire

// ----- hdl/kscu_cell.sv -----
// One cell of the table row: forward entry for its position and reverse
// entry for its letter. Uses kscu_pkg for widths and the push record.
`default_nettype none

module kscu_cell
    import kscu_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_index,     // fixed position of this cell
    input  wire t_push            i_push,
    input  wire logic [IDX_W-1:0] i_fwd_next,  // forward entry of the next cell
    output      logic [IDX_W-1:0] o_fwd,
    output      logic [IDX_W-1:0] o_rev
);

    logic [IDX_W-1:0] r_fwd;
    logic [IDX_W-1:0] r_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= i_index;
            r_rev <= i_index;
        end else begin
            // advance the forward row one cell toward the head
            if (i_push.shift) begin
                r_fwd <= i_fwd_next;
            end
            // capture the position at which this letter enters the row
            if (i_push.shift && (i_push.val == i_index)) begin
                r_rev <= i_push.pos;
            end
        end
    end

    assign o_fwd = r_fwd;
    assign o_rev = r_rev;

endmodule

`default_nettype wire

// ----- hdl/keyword_substitution_cipher_unit.sv -----
// Top level of the keyword substitution cipher unit.
// Uses kscu_pkg and instantiates one kscu_cell per alphabet letter.
//
// Usage:
//   Slave channel: tuser carries the action (open key, key letter, close key,
//   encode, decode), tdata carries the ASCII byte. Master channel: tdata
//   carries the result byte, tuser the status (ok, repeated key letter, not a
//   letter). Every accepted transfer gives exactly one result transfer.
//   Latency: a result is registered and shows on the master side the cycle
//   after its input transfer.
//   Open, key letter, encode and decode keep the unit in its idle state.
//   A close with no repeated letter rebuilds the tables by pushing letters
//   into the cell row: first the staged key letters in order, then the
//   unused letters found by a scan of the alphabet up to the last unused
//   letter. The slave side is not ready until the rebuild ends.
//   Reset: both tables return to the identity mapping, the staged key is
//   empty and the repeat flag is cleared.
//   Stall: a result waits in the output register; a new transfer is taken in
//   the same cycle the waiting one is taken by the receiver.
`default_nettype none

module keyword_substitution_cipher_unit
    import kscu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output      logic       o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_char
    input  wire logic [2:0] i_s_axis_tuser,   // [2:0] action
    output      logic       o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output      logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output      logic [1:0] o_m_axis_tuser    // [1:0] status
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_KEY  = 3'b010,   // push staged key letters
        S_SCAN = 3'b100    // push unused letters in alphabet order
    } t_state;

    t_state r_state, n_state;

    logic [ALPHABET_SIZE-1:0] r_mask, n_mask;
    logic [LEN_W-1:0]         r_key_len, n_key_len;
    logic                     r_repeat, n_repeat;
    logic [LEN_W-1:0]         r_cnt, n_cnt;
    logic [LEN_W-1:0]         r_pos, n_pos;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    t_status    r_out_status, n_out_status;

    // staged key letters, written at the key length
    logic [IDX_W-1:0] r_key_letters [ALPHABET_SIZE];
    logic             key_we;

    logic [IDX_W-1:0] fwd [ALPHABET_SIZE];
    logic [IDX_W-1:0] rev [ALPHABET_SIZE];
    t_push            push;

    logic             accept;
    logic             is_letter;
    logic [IDX_W-1:0] letter_idx;
    logic [8:0]       char_ext;
    logic [IDX_W-1:0] mapped;

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign char_ext   = {1'b0, i_s_axis_tdata};
    assign is_letter  = (char_ext >= LETTER_BASE) && (char_ext < LETTER_END);
    assign letter_idx = IDX_W'(char_ext - LETTER_BASE);
    assign mapped     = (i_s_axis_tuser == ACT_ENCODE) ? fwd[letter_idx] : rev[letter_idx];

    always_comb begin
        n_state      = r_state;
        n_mask       = r_mask;
        n_key_len    = r_key_len;
        n_repeat     = r_repeat;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_status = r_out_status;
        key_we       = 1'b0;
        push         = '0;

        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = i_s_axis_tdata;
                    n_out_status = ST_OK;
                    unique case (i_s_axis_tuser)
                        ACT_OPEN: begin
                            n_mask    = '0;
                            n_key_len = '0;
                            n_repeat  = 1'b0;
                        end
                        ACT_KEY: begin
                            if (!is_letter) begin
                                n_out_status = ST_NOT_LETTER;
                            end else if (r_mask[letter_idx]) begin
                                n_repeat     = 1'b1;
                                n_out_status = ST_REPEAT;
                            end else if (r_key_len < N_LEN) begin
                                key_we                 = 1'b1;
                                n_key_len              = r_key_len + 1'b1;
                                n_mask[letter_idx]     = 1'b1;
                            end
                        end
                        ACT_CLOSE: begin
                            if (r_repeat) begin
                                n_out_status = ST_REPEAT;
                            end else begin
                                n_cnt   = '0;
                                n_pos   = '0;
                                n_state = (r_key_len == '0) ? S_SCAN : S_KEY;
                            end
                        end
                        ACT_ENCODE, ACT_DECODE: begin
                            if (is_letter) begin
                                n_out_char = 8'(LETTER_BASE + 9'(mapped));
                            end else begin
                                n_out_status = ST_NOT_LETTER;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_KEY: begin
                push.shift = 1'b1;
                push.val   = r_key_letters[r_cnt[IDX_W-1:0]];
                push.pos   = r_pos[IDX_W-1:0];
                n_pos      = r_pos + 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (n_cnt == r_key_len) begin
                    n_cnt   = '0;
                    n_state = (r_key_len == N_LEN) ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (!r_mask[r_cnt[IDX_W-1:0]]) begin
                    push.shift = 1'b1;
                    push.val   = r_cnt[IDX_W-1:0];
                    push.pos   = r_pos[IDX_W-1:0];
                    n_pos      = r_pos + 1'b1;
                    if (n_pos == N_LEN) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mask       <= '0;
            r_key_len    <= '0;
            r_repeat     <= 1'b0;
            r_cnt        <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mask       <= n_mask;
            r_key_len    <= n_key_len;
            r_repeat     <= n_repeat;
            r_cnt        <= n_cnt;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_char   <= n_out_char;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_letters[r_key_len[IDX_W-1:0]] <= letter_idx;
        end
    end

    // row of cells: values enter at the tail and move toward cell 0
    for (genvar j = 0; j < ALPHABET_SIZE; j++) begin : g_cell
        logic [IDX_W-1:0] fwd_next;
        if (j == ALPHABET_SIZE - 1) begin : g_tail
            assign fwd_next = push.val;
        end else begin : g_body
            assign fwd_next = fwd[j+1];
        end
        kscu_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (IDX_W'(j)),
            .i_push     (push),
            .i_fwd_next (fwd_next),
            .o_fwd      (fwd[j]),
            .o_rev      (rev[j])
        );
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tuser  = r_out_status;

    // no new transfer while the row is rebuilding
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready)
        else $error("slave ready during table rebuild");

    // a clean close starts a rebuild on the next cycle
    a_close_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_s_axis_tuser == ACT_CLOSE) && !r_repeat) |=> (r_state != S_IDLE))
        else $error("close without repeat did not start a rebuild");

    // the row never takes more letters than it has cells
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.shift |-> (r_pos < N_LEN))
        else $error("push beyond the end of the cell row");

endmodule

`default_nettype wire
